FILE: src/padt_pkg.sv
// Package for the periodic advertiser table: item, result and entry types,
// operation and status codes. No dependencies.
package padt_pkg;

    // Operation codes carried in mode
    localparam logic [1:0] MODE_QUERY  = 2'd0;
    localparam logic [1:0] MODE_XFER   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Advertising kind that allows sync
    localparam logic [1:0] KIND_NONCONN_EXT = 2'd1;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic [7:0]  SET_ID_UNKNOWN = 8'hFF;
    localparam logic [15:0] RESET_INTERVAL = 16'd80;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] device_address;
        logic [1:0]  adv_kind;
        logic        has_aux_pointer;
        logic [15:0] report_interval;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        synced_flag;
        logic        changed;
        logic [15:0] entry_interval;
        logic [7:0]  entry_set_id;
    } result_t;

    typedef struct packed {
        logic [47:0] addr;
        logic        synced;
        logic [15:0] interval;
        logic [7:0]  set_id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: src/periodic_adv_device_table.sv
// Top level of the periodic advertiser table: default interval register,
// entry RAM and lookup sequencer. Depends on padt_pkg, padt_ram, padt_seq.
//
// An item is taken when start is high and busy is low. A query, report or
// accepted transfer compares the stored addresses one per cycle through a
// single comparator fed by the entry RAM's read port, then writes the found
// or appended entry back; a full table with the address absent gives a full
// result and writes nothing. done pulses in the first cycle with busy low.
// A refused transfer or an unused mode gives its result on the next cycle
// without raising busy. done marks each result for exactly one cycle and it
// must be captured then. The table itself is not cleared by reset; only the
// entry count is.
module periodic_adv_device_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [47:0] device_address,
    input  logic [1:0]  adv_kind,
    input  logic        has_aux_pointer,
    input  logic [15:0] report_interval,
    output logic        done,
    output logic [1:0]  status,
    output logic        synced_flag,
    output logic        changed,
    output logic [15:0] entry_interval,
    output logic [7:0]  entry_set_id
);

    import padt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [15:0]        default_interval_reg;
    item_t              item;
    result_t            result;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    // Default interval register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_interval_reg <= RESET_INTERVAL;
        end
        else if (cfg_wr_en)
        begin
            default_interval_reg <= cfg_wr_data;
        end
    end

    assign item = '{mode, device_address, adv_kind, has_aux_pointer, report_interval};

    // Entry store
    padt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    // Lookup sequencer
    padt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .item             (item),
        .default_interval (default_interval_reg),
        .busy             (busy),
        .done             (done),
        .result           (result),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata)
    );

    assign status         = result.status;
    assign synced_flag    = result.synced_flag;
    assign changed        = result.changed;
    assign entry_interval = result.entry_interval;
    assign entry_set_id   = result.entry_set_id;

    // A result follows either an accepted item or the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result without a preceding item");

    // A full-table result reaches no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FULL)) |->
            (entry_set_id == SET_ID_UNKNOWN) && (entry_interval == 16'd0)
            && !changed && !synced_flag)
        else $error("full-table result carries entry data");

    // Query answer and sync change never come from the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(synced_flag && changed))
        else $error("synced_flag and changed both set");

endmodule

FILE: src/padt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module padt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/padt_seq.sv
// Sequencer for the advertiser table: walks stored entries through one
// 48-bit address comparator, appends on a miss unless the table is full and writes the entry back.
// Depends on padt_pkg; drives one padt_ram instance held by the top level.
module padt_seq #(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  padt_pkg::item_t    item,
    input  logic [15:0]        default_interval,
    output logic               busy,
    output logic               done,
    output padt_pkg::result_t  result,
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output padt_pkg::entry_t   ram_wdata,
    output logic [IDX_W-1:0]   ram_raddr,
    input  padt_pkg::entry_t   ram_rdata
);

    import padt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]       state_reg, state_next;
    item_t            item_reg, item_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    entry_t           ent_reg, ent_next;
    result_t          res_reg, res_next;
    logic             done_reg, done_next;

    logic   match;
    logic   last_chk;
    entry_t upd;
    logic   upd_synced;
    logic   upd_changed;

    // Shared comparator: stored address read last cycle against the key
    assign match    = chk_vld_reg && (ram_rdata.addr == item_reg.device_address);
    assign last_chk = chk_vld_reg && (chk_idx_reg == count_reg - CNT_W'(1));

    // Entry update for the found or appended entry
    always_comb
    begin
        upd         = ent_reg;
        upd_synced  = 1'b0;
        upd_changed = 1'b0;
        case (item_reg.mode)
            MODE_QUERY:
            begin
                upd_synced = (item_reg.adv_kind == KIND_NONCONN_EXT) && ent_reg.synced;
            end
            MODE_XFER:
            begin
                upd.set_id   = 8'd0;
                upd.interval = default_interval;
            end
            MODE_REPORT:
            begin
                if ((item_reg.adv_kind == KIND_NONCONN_EXT) && item_reg.has_aux_pointer
                    && !ent_reg.synced)
                begin
                    upd.synced   = 1'b1;
                    upd.interval = (item_reg.report_interval != 16'd0) ?
                                   item_reg.report_interval : default_interval;
                    upd_changed  = 1'b1;
                end
            end
            default:
            begin
                upd = ent_reg;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        scan_idx_next = scan_idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = 1'b0;
        count_next    = count_reg;
        slot_next     = slot_reg;
        ent_next      = ent_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next     = item;
                    scan_idx_next = '0;
                    if ((item.mode == MODE_XFER) && (item.adv_kind != KIND_NONCONN_EXT))
                    begin
                        res_next  = '{STAT_INVALID, 1'b0, 1'b0, 16'd0, SET_ID_UNKNOWN};
                        done_next = 1'b1;
                    end
                    else if (item.mode == MODE_NONE)
                    begin
                        res_next  = '{STAT_OK, 1'b0, 1'b0, 16'd0, SET_ID_UNKNOWN};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle, compare it the cycle after
                if (scan_idx_reg < count_reg)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    chk_vld_next  = 1'b1;
                end
                chk_idx_next = scan_idx_reg;
                if (match)
                begin
                    ent_next   = ram_rdata;
                    slot_next  = chk_idx_reg[IDX_W-1:0];
                    state_next = ST_UPDATE;
                end
                else if ((count_reg == '0) || last_chk)
                begin
                    if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_next   = '{STAT_FULL, 1'b0, 1'b0, 16'd0, SET_ID_UNKNOWN};
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ent_next   = '{item_reg.device_address, 1'b0, 16'd0, SET_ID_UNKNOWN};
                        slot_next  = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                ram_we     = 1'b1;
                res_next   = '{STAT_OK, upd_synced, upd_changed, upd.interval, upd.set_id};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        slot_reg     <= slot_next;
        ent_reg      <= ent_next;
        res_reg      <= res_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign ram_waddr = slot_reg;
    assign ram_wdata = upd;
    assign ram_raddr = scan_idx_reg[IDX_W-1:0];

endmodule
